FILE: sv/cia_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the checked integer ALU.
package cia_pkg;

    localparam int PORT_W = 64;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_MOD = 3'd4,
        CMD_POW = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK  = 2'd0,
        ST_OVF = 2'd1,
        ST_INV = 2'd2
    } t_status;

    typedef enum logic {
        UOP_MUL = 1'b0,
        UOP_DIV = 1'b1
    } t_uop;

    typedef struct packed {
        logic start;
        t_uop op;
    } t_ureq;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_ursp;

endpackage

FILE: sv/cia_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command and result words.
interface cia_in_if import cia_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [PORT_W-1:0] operand_a;
    logic signed [PORT_W-1:0] operand_b;

    modport source (output valid, cmd, operand_a, operand_b, input ready);
    modport sink (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface cia_out_if import cia_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [PORT_W-1:0] result;
    logic [STAT_W-1:0]        status;

    modport source (output valid, result, status, input ready);
    modport sink (input valid, result, status, output ready);
endinterface

FILE: sv/cia_muldiv.sv
`timescale 1ns / 1ps
// Iterative shift-add multiplier / restoring divider sharing one adder.
module cia_muldiv import cia_pkg::*; #(
    parameter int W = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ureq               i_req,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    output t_ursp               o_rsp,
    output logic signed [W-1:0] o_prod,
    output logic [W-2:0]        o_rem
);
    localparam int CW = $clog2(W);

    logic [W-1:0]  r_hi, n_hi;
    logic [W-2:0]  r_lo, n_lo;
    logic [W-2:0]  r_v;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done, r_neg;
    t_uop          r_op;

    logic [W-1:0] w_xm, w_ym, w_t;
    logic [W:0]   w_opa, w_opb, w_sum;
    logic         w_sub;

    assign w_xm = i_x[W-1] ? -i_x : i_x;
    assign w_ym = i_y[W-1] ? -i_y : i_y;
    assign w_t  = {r_hi[W-2:0], r_lo[W-2]};

    always_comb begin
        w_sub = (r_op == UOP_DIV);
        if (w_sub) begin
            w_opa = {1'b0, w_t};
            w_opb = {2'b00, r_v};
        end else begin
            w_opa = {1'b0, r_hi};
            w_opb = r_lo[0] ? {2'b00, r_v} : '0;
        end
        w_sum = w_opa + (w_sub ? ~w_opb : w_opb) + {{W{1'b0}}, w_sub};
        if (w_sub) begin
            if (w_sum[W]) begin
                n_hi = w_t;
                n_lo = {r_lo[W-3:0], 1'b0};
            end else begin
                n_hi = w_sum[W-1:0];
                n_lo = {r_lo[W-3:0], 1'b1};
            end
        end else begin
            n_hi = w_sum[W:1];
            n_lo = {w_sum[0], r_lo[W-2:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= UOP_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_op   <= i_req.op;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 2)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_hi  <= '0;
            r_lo  <= (i_req.op == UOP_DIV) ? w_xm[W-2:0] : w_ym[W-2:0];
            r_v   <= (i_req.op == UOP_DIV) ? w_ym[W-2:0] : w_xm[W-2:0];
            r_neg <= i_x[W-1] ^ i_y[W-1];
        end else if (r_busy) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = (r_hi != '0);
    assign o_prod     = r_neg ? -{1'b0, r_lo} : {1'b0, r_lo};
    assign o_rem      = r_hi[W-2:0];

endmodule

FILE: sv/checked_integer_alu.sv
`timescale 1ns / 1ps
// Top level of the checked integer ALU: sequencer around a shared mul/div unit.
// Add, subtract and most flagged cases: result word settled in S_DEC, then offered from S_DONE.
// Multiply, divide, modulo: the result waits on the one-bit-per-cycle unit.
// Power: up to 11 unit passes at 64 bits.
// One word in flight; input ready again in the cycle after the result is taken.
// Sync active-low reset clears control.
module checked_integer_alu import cia_pkg::*; #(
    parameter int WORD_BITS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cia_in_if.sink     i_in,
    cia_out_if.source  o_out
);
    localparam int W = WORD_BITS;
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE  = W'(1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DEC   = 9'b000000010,
        S_MUL   = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_PSTEP = 9'b000010000,
        S_PMUL  = 9'b000100000,
        S_PNEXT = 9'b001000000,
        S_PSQ   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    t_cmd                r_cmd;
    logic signed [W-1:0] r_a, r_b, r_acc, n_acc, r_sq, n_sq, r_res, n_res;
    logic [W-2:0]        r_e, n_e, w_e_sh;
    t_status             r_st, n_st;

    t_ureq               w_req;
    t_ursp               w_rsp;
    logic signed [W-1:0] w_x, w_y, w_prod, w_bmag, w_mod;
    logic [W-2:0]        w_rem;
    logic signed [W:0]   w_sum;

    cia_muldiv #(.W(W)) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_x     (w_x),
        .i_y     (w_y),
        .o_rsp   (w_rsp),
        .o_prod  (w_prod),
        .o_rem   (w_rem)
    );

    assign w_sum  = (r_cmd == CMD_SUB) ? (W+1)'(r_a) - (W+1)'(r_b)
                                       : (W+1)'(r_a) + (W+1)'(r_b);
    assign w_bmag = r_b[W-1] ? -r_b : r_b;
    assign w_mod  = (r_a[W-1] && w_rem != '0) ? w_bmag - {1'b0, w_rem} : {1'b0, w_rem};
    assign w_e_sh = r_e >> 1;

    always_comb begin
        n_state   = r_state;
        n_acc     = r_acc;
        n_sq      = r_sq;
        n_e       = r_e;
        n_res     = r_res;
        n_st      = r_st;
        w_req     = '{start: 1'b0, op: UOP_MUL};
        w_x       = r_a;
        w_y       = r_b;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_DONE;
                n_res   = '0;
                n_st    = ST_OK;
                if (r_a == MINV || r_b == MINV) begin
                    n_st = ST_OVF;
                end else begin
                    case (r_cmd)
                        CMD_ADD, CMD_SUB: begin
                            if (w_sum[W] != w_sum[W-1] || w_sum[W-1:0] == MINV) begin
                                n_st = ST_OVF;
                            end else begin
                                n_res = w_sum[W-1:0];
                            end
                        end
                        CMD_MUL: begin
                            w_req   = '{start: 1'b1, op: UOP_MUL};
                            n_state = S_MUL;
                        end
                        CMD_DIV, CMD_MOD: begin
                            if (r_b == '0) begin
                                n_st = ST_INV;
                            end else begin
                                w_req   = '{start: 1'b1, op: UOP_DIV};
                                n_state = S_DIV;
                            end
                        end
                        CMD_POW: begin
                            if (r_b[W-1]) begin
                                n_st = ST_INV;
                            end else if (r_a == '0 || r_a == ONE) begin
                                n_res = r_a;
                            end else if (r_a == -ONE) begin
                                n_res = r_b[0] ? -ONE : ONE;
                            end else begin
                                n_acc   = ONE;
                                n_sq    = r_a;
                                n_e     = r_b[W-2:0];
                                n_state = S_PSTEP;
                            end
                        end
                        default: n_st = ST_INV;
                    endcase
                end
            end
            S_MUL: begin
                if (w_rsp.done) begin
                    n_state = S_DONE;
                    n_st    = w_rsp.ovf ? ST_OVF : ST_OK;
                    n_res   = w_rsp.ovf ? '0 : w_prod;
                end
            end
            S_DIV: begin
                if (w_rsp.done) begin
                    n_state = S_DONE;
                    n_st    = ST_OK;
                    n_res   = (r_cmd == CMD_DIV) ? w_prod : w_mod;
                end
            end
            S_PSTEP: begin
                if (r_e[0]) begin
                    w_req   = '{start: 1'b1, op: UOP_MUL};
                    w_x     = r_acc;
                    w_y     = r_sq;
                    n_state = S_PMUL;
                end else begin
                    n_state = S_PNEXT;
                end
            end
            S_PMUL: begin
                if (w_rsp.done) begin
                    if (w_rsp.ovf) begin
                        n_st    = ST_OVF;
                        n_res   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_acc   = w_prod;
                        n_state = S_PNEXT;
                    end
                end
            end
            S_PNEXT: begin
                n_e = w_e_sh;
                if (w_e_sh != '0) begin
                    w_req   = '{start: 1'b1, op: UOP_MUL};
                    w_x     = r_sq;
                    w_y     = r_sq;
                    n_state = S_PSQ;
                end else begin
                    n_res   = r_acc;
                    n_st    = ST_OK;
                    n_state = S_DONE;
                end
            end
            S_PSQ: begin
                if (w_rsp.done) begin
                    if (w_rsp.ovf) begin
                        n_st    = ST_OVF;
                        n_res   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_sq    = w_prod;
                        n_state = S_PSTEP;
                    end
                end
            end
            S_DONE: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_OK;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_sq  <= n_sq;
        r_e   <= n_e;
        r_res <= n_res;
        if (r_state == S_IDLE && i_in.valid) begin
            r_cmd <= t_cmd'(i_in.cmd);
            r_a   <= i_in.operand_a[W-1:0];
            r_b   <= i_in.operand_b[W-1:0];
        end
    end

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = (r_state == S_DONE);
    assign o_out.result = PORT_W'(r_res);
    assign o_out.status = r_st;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_MUL || r_state == S_DIV ||
                        r_state == S_PMUL || r_state == S_PSQ))
        else $error("unit finished outside a wait state");
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_st != ST_OK) |-> (r_res == '0))
        else $error("flagged word carries nonzero result");
    a_accept_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_DEC))
        else $error("accepted word not decoded");
`endif

endmodule
